// ----- rtl/bsb_pkg.sv -----
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types, widths and fixed-point helpers for the bond stiffness block.
// ----------------------------------------------------------------------------
package bsb_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;

    // Register indexes, byte address = 4 * index
    localparam logic [IDX_W-1:0] REG_THREE_D = 2'd0;
    localparam logic [IDX_W-1:0] REG_C11     = 2'd1;
    localparam logic [IDX_W-1:0] REG_C12     = 2'd2;
    localparam logic [IDX_W-1:0] REG_C66     = 2'd3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic  bond_alive;
        data_t gxx;
        data_t gyy;
        data_t gzz;
        data_t gxy;
        data_t gxz;
        data_t gyz;
        data_t dux;
        data_t duy;
        data_t duz;
    } bsb_in_t;

    typedef struct packed {
        data_t res_x;
        data_t res_y;
        data_t res_z;
        data_t coef_xx;
        data_t coef_yy;
        data_t coef_zz;
        data_t coef_xy;
        data_t coef_xz;
        data_t coef_yz;
    } bsb_out_t;

    typedef struct packed {
        logic  three_d;
        data_t c11;
        data_t c12;
        data_t c66;
    } bsb_cfg_t;

    // Coefficient block plus the displacement it applies to
    typedef struct packed {
        data_t pxx;
        data_t pyy;
        data_t pzz;
        data_t pxy;
        data_t pxz;
        data_t pyz;
        data_t dux;
        data_t duy;
        data_t duz;
    } bsb_coef_t;

    function automatic sum_t sx(input prod_t p);
        return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // Floor shift by the fraction bits, then clamp to the data range
    function automatic data_t sat_frac(input sum_t s);
        sum_t sh;
        sum_t hi_lim;
        sum_t lo_lim;
        sh     = s >>> FRAC_W;
        hi_lim = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo_lim = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (sh > hi_lim) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sh < lo_lim) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return sh[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/navier_bond_stiffness_block_unit.sv -----
// ----------------------------------------------------------------------------
// navier_bond_stiffness_block_unit: peridynamic Navier bond stiffness block
// One bond per cycle sustained while m_ready is held high, through the
// five-stage multiply/sum pipeline.
// Synchronous active-low reset empties the pipeline and zeroes the config registers.
// ----------------------------------------------------------------------------
module navier_bond_stiffness_block_unit import bsb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bsb_in_t           s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output bsb_out_t          m_payload,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    bsb_cfg_t   cfg_reg;
    logic       cfg_wr;
    logic [IDX_W-1:0] cfg_idx;
    logic       mid_valid;
    logic       mid_ready;
    bsb_coef_t  mid_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THREE_D: cfg_reg.three_d <= pwdata[0];
                REG_C11:     cfg_reg.c11     <= pwdata[DATA_W-1:0];
                REG_C12:     cfg_reg.c12     <= pwdata[DATA_W-1:0];
                REG_C66:     cfg_reg.c66     <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THREE_D: prdata = {{(APB_W-1){1'b0}}, cfg_reg.three_d};
            REG_C11:     prdata = cfg_reg.c11;
            REG_C12:     prdata = cfg_reg.c12;
            REG_C66:     prdata = cfg_reg.c66;
            default:     prdata = '0;
        endcase
    end

    bsb_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    bsb_resid u_resid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

endmodule

// ----- rtl/bsb_coef.sv -----
// ----------------------------------------------------------------------------
// bsb_coef
// Input register, elastic-constant products and saturated coefficient sums.
// ----------------------------------------------------------------------------
module bsb_coef import bsb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  bsb_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  bsb_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output bsb_coef_t out_data
);

    logic      s1_valid_reg;
    bsb_in_t   s1_data_reg;
    logic      s1_td_reg;
    logic      s2_valid_reg;
    logic      s2_alive_reg;
    logic      s2_td_reg;
    data_t     s2_dux_reg;
    data_t     s2_duy_reg;
    data_t     s2_duz_reg;
    prod_t     p11_xx_reg, p66_yy_reg, p66_zz_reg;
    prod_t     p11_yy_reg, p66_xx_reg, p11_zz_reg;
    prod_t     p12_xy_reg, p66_xy_reg;
    prod_t     p12_xz_reg, p66_xz_reg;
    prod_t     p12_yz_reg, p66_yz_reg;
    logic      s3_valid_reg;
    bsb_coef_t s3_data_reg;
    bsb_in_t   s1_data_next;
    bsb_coef_t s3_data_next;
    logic      s1_ready;
    logic      s2_ready;
    logic      s3_ready;

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

    // Drop the z terms in plane mode
    always_comb begin
        s1_data_next = in_data;
        if (!cfg.three_d) begin
            s1_data_next.gzz = '0;
            s1_data_next.gxz = '0;
            s1_data_next.gyz = '0;
            s1_data_next.duz = '0;
        end
    end

    always_comb begin
        sum_t sxx;
        sum_t syy;
        sum_t szz;
        sum_t sxy;
        sum_t sxz;
        sum_t syz;
        sxx = sx(p11_xx_reg) + sx(p66_yy_reg) + sx(p66_zz_reg);
        syy = sx(p11_yy_reg) + sx(p66_xx_reg) + sx(p66_zz_reg);
        szz = sx(p11_zz_reg) + sx(p66_xx_reg) + sx(p66_yy_reg);
        sxy = sx(p12_xy_reg) + sx(p66_xy_reg);
        sxz = sx(p12_xz_reg) + sx(p66_xz_reg);
        syz = sx(p12_yz_reg) + sx(p66_yz_reg);
        s3_data_next.pxx = sat_frac(sxx);
        s3_data_next.pyy = sat_frac(syy);
        s3_data_next.pzz = sat_frac(szz);
        s3_data_next.pxy = sat_frac(sxy);
        s3_data_next.pxz = sat_frac(sxz);
        s3_data_next.pyz = sat_frac(syz);
        s3_data_next.dux = s2_dux_reg;
        s3_data_next.duy = s2_duy_reg;
        s3_data_next.duz = s2_duz_reg;
        if (!s2_td_reg) begin
            s3_data_next.pzz = '0;
            s3_data_next.pxz = '0;
            s3_data_next.pyz = '0;
        end
        // a broken bond zeroes the block, and so the residual
        if (!s2_alive_reg) begin
            s3_data_next.pxx = '0;
            s3_data_next.pyy = '0;
            s3_data_next.pzz = '0;
            s3_data_next.pxy = '0;
            s3_data_next.pxz = '0;
            s3_data_next.pyz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_data_reg <= s1_data_next;
            s1_td_reg   <= cfg.three_d;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_alive_reg <= s1_data_reg.bond_alive;
            s2_td_reg    <= s1_td_reg;
            s2_dux_reg   <= s1_data_reg.dux;
            s2_duy_reg   <= s1_data_reg.duy;
            s2_duz_reg   <= s1_data_reg.duz;
            p11_xx_reg   <= prod_t'(cfg.c11) * prod_t'(s1_data_reg.gxx);
            p66_yy_reg   <= prod_t'(cfg.c66) * prod_t'(s1_data_reg.gyy);
            p66_zz_reg   <= prod_t'(cfg.c66) * prod_t'(s1_data_reg.gzz);
            p11_yy_reg   <= prod_t'(cfg.c11) * prod_t'(s1_data_reg.gyy);
            p66_xx_reg   <= prod_t'(cfg.c66) * prod_t'(s1_data_reg.gxx);
            p11_zz_reg   <= prod_t'(cfg.c11) * prod_t'(s1_data_reg.gzz);
            p12_xy_reg   <= prod_t'(cfg.c12) * prod_t'(s1_data_reg.gxy);
            p66_xy_reg   <= prod_t'(cfg.c66) * prod_t'(s1_data_reg.gxy);
            p12_xz_reg   <= prod_t'(cfg.c12) * prod_t'(s1_data_reg.gxz);
            p66_xz_reg   <= prod_t'(cfg.c66) * prod_t'(s1_data_reg.gxz);
            p12_yz_reg   <= prod_t'(cfg.c12) * prod_t'(s1_data_reg.gyz);
            p66_yz_reg   <= prod_t'(cfg.c66) * prod_t'(s1_data_reg.gyz);
        end
        if (s3_ready && s2_valid_reg) begin
            s3_data_reg <= s3_data_next;
        end
    end

endmodule

// ----- rtl/bsb_resid.sv -----
// ----------------------------------------------------------------------------
// bsb_resid
// Block times displacement products and saturated residual sums.
// ----------------------------------------------------------------------------
module bsb_resid import bsb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  bsb_coef_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output bsb_out_t  out_data
);

    logic      s4_valid_reg;
    bsb_coef_t s4_coef_reg;
    prod_t     pxx_dx_reg, pxy_dy_reg, pxz_dz_reg;
    prod_t     pxy_dx_reg, pyy_dy_reg, pyz_dz_reg;
    prod_t     pxz_dx_reg, pyz_dy_reg, pzz_dz_reg;
    logic      s5_valid_reg;
    bsb_out_t  s5_data_reg;
    bsb_out_t  s5_data_next;
    logic      s4_ready;
    logic      s5_ready;

    assign s5_ready  = !s5_valid_reg || out_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign in_ready  = s4_ready;
    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

    always_comb begin
        sum_t sum_x;
        sum_t sum_y;
        sum_t sum_z;
        sum_x = sx(pxx_dx_reg) + sx(pxy_dy_reg) + sx(pxz_dz_reg);
        sum_y = sx(pxy_dx_reg) + sx(pyy_dy_reg) + sx(pyz_dz_reg);
        sum_z = sx(pxz_dx_reg) + sx(pyz_dy_reg) + sx(pzz_dz_reg);
        s5_data_next.res_x   = sat_frac(sum_x);
        s5_data_next.res_y   = sat_frac(sum_y);
        s5_data_next.res_z   = sat_frac(sum_z);
        s5_data_next.coef_xx = s4_coef_reg.pxx;
        s5_data_next.coef_yy = s4_coef_reg.pyy;
        s5_data_next.coef_zz = s4_coef_reg.pzz;
        s5_data_next.coef_xy = s4_coef_reg.pxy;
        s5_data_next.coef_xz = s4_coef_reg.pxz;
        s5_data_next.coef_yz = s4_coef_reg.pyz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s4_ready) begin
                s4_valid_reg <= in_valid;
            end
            if (s5_ready) begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready && in_valid) begin
            s4_coef_reg <= in_data;
            pxx_dx_reg  <= prod_t'(in_data.pxx) * prod_t'(in_data.dux);
            pxy_dy_reg  <= prod_t'(in_data.pxy) * prod_t'(in_data.duy);
            pxz_dz_reg  <= prod_t'(in_data.pxz) * prod_t'(in_data.duz);
            pxy_dx_reg  <= prod_t'(in_data.pxy) * prod_t'(in_data.dux);
            pyy_dy_reg  <= prod_t'(in_data.pyy) * prod_t'(in_data.duy);
            pyz_dz_reg  <= prod_t'(in_data.pyz) * prod_t'(in_data.duz);
            pxz_dx_reg  <= prod_t'(in_data.pxz) * prod_t'(in_data.dux);
            pyz_dy_reg  <= prod_t'(in_data.pyz) * prod_t'(in_data.duy);
            pzz_dz_reg  <= prod_t'(in_data.pzz) * prod_t'(in_data.duz);
        end
        if (s5_ready && s4_valid_reg) begin
            s5_data_reg <= s5_data_next;
        end
    end

endmodule

// ----- rtl/bsb_checker.sv -----
// ----------------------------------------------------------------------------
// bsb_checker
// Port-level checks on the bond stiffness block, bound to the top level.
// ----------------------------------------------------------------------------
module bsb_checker import bsb_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input bsb_out_t          m_payload
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result word changed");

    // no z coupling means no z residual
    a_plane_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.coef_zz == '0 && m_payload.coef_xz == '0 &&
        m_payload.coef_yz == '0 |-> m_payload.res_z == '0)
        else $error("z residual without z coupling");

    // zero block gives zero x and y residual
    a_zero_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.coef_xx == '0 && m_payload.coef_yy == '0 &&
        m_payload.coef_zz == '0 && m_payload.coef_xy == '0 &&
        m_payload.coef_xz == '0 && m_payload.coef_yz == '0
        |-> m_payload.res_x == '0 && m_payload.res_y == '0)
        else $error("residual from zero block");

endmodule

bind navier_bond_stiffness_block_unit bsb_checker u_bsb_checker (.*);
